// File: rtl/mcsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsm_pkg: mapping cache slot manager shared definitions
// Sizes, field widths and the records passed along the slot cell row.
// ----------------------------------------------------------------------------
package mcsm_pkg;

   // Geometry. Bank count and entries per map page are powers of two, so the
   // bank and entry fields are plain bit slices of the logical page number.
   localparam int BANK_COUNT           = 4;
   localparam int SLOTS_PER_BANK       = 8;
   localparam int ENTRIES_PER_MAP_PAGE = 8;
   localparam int LPN_BITS             = 24;
   localparam int AGE_BITS             = 16;

   localparam int BANK_W  = $clog2(BANK_COUNT);
   localparam int SLOT_W  = $clog2(SLOTS_PER_BANK);
   localparam int ENTRY_W = $clog2(ENTRIES_PER_MAP_PAGE);
   localparam int TAG_W   = LPN_BITS - BANK_W - ENTRY_W;

   // Stream beat widths, padded to whole bytes
   localparam int REQ_DATA_W = ((LPN_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = BANK_W + SLOT_W + ENTRY_W + 2 + 2 * TAG_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef logic [BANK_W-1:0]   bank_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [ENTRY_W-1:0]  entry_type;
   typedef logic [TAG_W-1:0]    tag_type;
   typedef logic [AGE_BITS-1:0] age_type;

   // Search record handed from cell to cell
   typedef struct packed {
      logic     hit;
      slot_type hit_slot;
      logic     empty;
      slot_type empty_slot;
      logic     best;
      slot_type best_slot;
      age_type  best_age;
      tag_type  best_tag;
      logic     best_dirty;
   } chain_type;

   // Update broadcast to every cell once the slot is chosen
   typedef struct packed {
      logic     en;
      bank_type bank;
      slot_type slot;
      tag_type  tag;
      logic     install;
      logic     write;
   } update_type;

endpackage
`default_nettype wire

// File: rtl/mcsm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcsm_cell: one slot position of every bank
// Holds tag, valid, dirty and age of its slot for all banks, folds its own
// entry into the search record from its neighbour and applies the update.
// ----------------------------------------------------------------------------
module mcsm_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mcsm_pkg::slot_type   slot_id,
   input  wire mcsm_pkg::bank_type   bank_sel,
   input  wire mcsm_pkg::tag_type    lookup_tag,
   input  wire mcsm_pkg::chain_type  chain_in,
   output mcsm_pkg::chain_type       chain_out,
   input  wire mcsm_pkg::update_type update
);
   import mcsm_pkg::*;

   tag_type tag_ff   [BANK_COUNT];
   logic    valid_ff [BANK_COUNT];
   logic    dirty_ff [BANK_COUNT];
   age_type age_ff   [BANK_COUNT];

   tag_type rd_tag;
   logic    rd_valid;
   logic    rd_dirty;
   age_type rd_age;
   logic    match;
   logic    take_best;

   tag_type up_tag;
   logic    up_valid;
   logic    up_dirty;
   age_type up_age;
   logic    mine;

   // read this slot of the requested bank
   always_comb begin
      rd_tag   = tag_ff[bank_sel];
      rd_valid = valid_ff[bank_sel];
      rd_dirty = dirty_ff[bank_sel];
      rd_age   = age_ff[bank_sel];
   end

   // fold own entry into the search record: first hit, last empty, oldest
   always_comb begin
      match     = rd_valid && (rd_tag == lookup_tag);
      take_best = !chain_in.best || (rd_age > chain_in.best_age);
      chain_out = chain_in;
      if (!chain_in.hit && match) begin
         chain_out.hit      = 1'b1;
         chain_out.hit_slot = slot_id;
      end
      if (!rd_valid) begin
         chain_out.empty      = 1'b1;
         chain_out.empty_slot = slot_id;
      end
      if (take_best) begin
         chain_out.best       = 1'b1;
         chain_out.best_slot  = slot_id;
         chain_out.best_age   = rd_age;
         chain_out.best_tag   = rd_tag;
         chain_out.best_dirty = rd_dirty;
      end
   end

   // next entry for the updated bank
   always_comb begin
      mine     = (update.slot == slot_id);
      up_tag   = tag_ff[update.bank];
      up_valid = valid_ff[update.bank];
      up_dirty = dirty_ff[update.bank];
      up_age   = age_ff[update.bank];
      if (mine) begin
         up_age = '0;
         if (update.install) begin
            up_tag   = update.tag;
            up_valid = 1'b1;
            up_dirty = 1'b0;
         end
         if (update.write) begin
            up_dirty = 1'b1;
         end
      end else if (up_age != {AGE_BITS{1'b1}}) begin
         up_age = up_age + age_type'(1);
      end
   end

   // control and age state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANK_COUNT; b++) begin
            valid_ff[b] <= 1'b0;
            dirty_ff[b] <= 1'b0;
            age_ff[b]   <= '0;
         end
      end else if (update.en) begin
         valid_ff[update.bank] <= up_valid;
         dirty_ff[update.bank] <= up_dirty;
         age_ff[update.bank]   <= up_age;
      end
   end

   // tags need no reset: only compared while valid
   always_ff @(posedge clock) begin
      if (update.en) begin
         tag_ff[update.bank] <= up_tag;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mapping_cache_slot_manager.sv
`timescale 1ns / 1ps
`default_nettype none
// A request beat is held in the single request register while the slot cell
// row searches and updates the bank and its result beat is loaded into the
// result register. No new request is taken until the held beat has moved on.
// A waiting result beat holds the next request in the request register.
// Reset: synchronous; clears every valid bit, dirty bit and age at once.
// ----------------------------------------------------------------------------
// mapping_cache_slot_manager: cached mapping table slot manager
// Splits a logical page number into bank, map page and entry, searches the
// bank's slots through a row of slot cells and reports hit, fill and eviction.
// ----------------------------------------------------------------------------
module mapping_cache_slot_manager (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request beat
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [mcsm_pkg::REQ_DATA_W-1:0]     req_tdata,  // lpn
   input  wire logic                                req_tuser,  // command
   // result beat
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // bank, slot, entry_index, hit, writeback, evicted_page, fill_page
   output logic [mcsm_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import mcsm_pkg::*;

   logic                  pend_ff;
   logic                  cmd_ff;
   logic [LPN_BITS-1:0]   lpn_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   bank_type   bank;
   entry_type  entry;
   tag_type    tag;
   logic       fire;
   chain_type  chain [SLOTS_PER_BANK+1];
   chain_type  found;
   update_type update;
   slot_type   chosen;
   logic       hit;
   logic       wb;
   tag_type    evicted;
   tag_type    fill;

   assign req_tready = !pend_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // split the page number
   assign bank  = lpn_ff[BANK_W-1:0];
   assign entry = lpn_ff[BANK_W +: ENTRY_W];
   assign tag   = lpn_ff[LPN_BITS-1 -: TAG_W];
   assign fire  = pend_ff && (!rsp_valid_ff || rsp_tready);

   // hold the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         pend_ff <= 1'b1;
      end else if (fire) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tuser;
         lpn_ff <= req_tdata[LPN_BITS-1:0];
      end
   end

   // slot cell row
   assign chain[0] = '0;

   for (genvar i = 0; i < SLOTS_PER_BANK; i++) begin : g_cell
      mcsm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_id    (slot_type'(i)),
         .bank_sel   (bank),
         .lookup_tag (tag),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .update     (update)
      );
   end

   assign found = chain[SLOTS_PER_BANK];

   // choose slot: hit, else last empty, else oldest
   always_comb begin
      hit = found.hit;
      priority if (found.hit) begin
         chosen = found.hit_slot;
      end else if (found.empty) begin
         chosen = found.empty_slot;
      end else begin
         chosen = found.best_slot;
      end
      wb      = !found.hit && !found.empty && found.best_dirty;
      evicted = wb ? found.best_tag : '0;
      fill    = hit ? '0 : tag;

      update.en      = fire;
      update.bank    = bank;
      update.slot    = chosen;
      update.tag     = tag;
      update.install = !hit;
      update.write   = cmd_ff;

      rsp_data_in = RSP_DATA_W'({fill, evicted, wb, hit, entry, chosen, bank});
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire
